>>> hw/rtl/rlm_pkg.sv
package rlm_pkg;

	// Largest block is 2**COUNT_LOG2 samples
	localparam int COUNT_LOG2 = 20;

	localparam int SAMPLE_W = 16;
	localparam int SQ_W     = 2 * SAMPLE_W - 1;
	localparam int SUM_W    = SQ_W + COUNT_LOG2;
	localparam int CNT_W    = COUNT_LOG2 + 1;
	localparam int MEAN_W   = SQ_W;
	localparam int RMS_W    = SAMPLE_W;

	localparam int ACC_STEP_W  = $clog2(SAMPLE_W);
	localparam int DIV_STEP_W  = $clog2(SUM_W);
	localparam int ROOT_STEP_W = $clog2(RMS_W);

	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(1) << COUNT_LOG2;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

>>> hw/rtl/rms_level_meter.sv
// While a sample is squared into the sum, one multiplier bit per cycle, the input stalls.
// A sample arriving on a full count is not added to the sum; it sets the overflow flag.
// A last sample returns its result word after 16 square steps (none on a full count),
// 51 divide steps (one quotient bit each) and 16 root steps (two radicand bits each).
// Reset (arst_n low, asynchronous) clears the sum, the count, the overflow flag and
// all handshake state; the block can take a sample as soon as reset is released.
module rms_level_meter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [rlm_pkg::SAMPLE_W-1:0] sample,
	input  logic                              last_sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rlm_pkg::RMS_W-1:0]         rms,
	output logic [rlm_pkg::CNT_W-1:0]         sample_count,
	output logic                              count_overflow
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_ROOT = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]                    state_q;
	logic [rlm_pkg::CNT_W-1:0]     count_q;
	logic                          ovf_q;
	logic                          last_q;
	logic [rlm_pkg::CNT_W-1:0]     res_count_q;
	logic                          res_ovf_q;
	logic                          out_valid_q;
	logic [rlm_pkg::RMS_W-1:0]     rms_q;
	logic [rlm_pkg::CNT_W-1:0]     out_count_q;
	logic                          out_ovf_q;

	logic                          in_take;
	logic                          full;
	logic [rlm_pkg::SAMPLE_W-1:0]  mag;
	logic                          acc_start;
	logic                          div_start;
	logic                          root_start;
	logic                          out_load;
	logic [rlm_pkg::SUM_W-1:0]     sum;
	logic [rlm_pkg::SUM_W-1:0]     quotient;
	logic [rlm_pkg::MEAN_W-1:0]    mean;
	logic [rlm_pkg::RMS_W-1:0]     root;
	rlm_pkg::unit_stat_t           acc_stat;
	rlm_pkg::unit_stat_t           div_stat;
	rlm_pkg::unit_stat_t           root_stat;

	assign in_stall = state_q != ST_IDLE;
	assign in_take  = in_valid && !in_stall;
	assign full     = count_q == rlm_pkg::MAX_COUNT;
	// two's complement magnitude; the most negative sample maps to 2**15
	assign mag      = sample[rlm_pkg::SAMPLE_W-1] ? rlm_pkg::SAMPLE_W'(-sample)
	                                               : rlm_pkg::SAMPLE_W'(sample);

	assign acc_start  = in_take && !full;
	assign div_start  = (in_take && full && last_sample) ||
	                    (state_q == ST_ACC && acc_stat.done && last_q);
	assign root_start = state_q == ST_DIV && div_stat.done;
	assign out_load   = state_q == ST_OUT && (!out_valid_q || !out_stall);
	assign mean       = (res_count_q == '0) ? '0 : rlm_pkg::MEAN_W'(quotient);

	rlm_sq_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (acc_start),
		.clear  (div_start),
		.mag    (mag),
		.sum    (sum),
		.stat   (acc_stat)
	);

	rlm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum),
		.divisor  (count_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	rlm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (mean),
		.root     (root),
		.stat     (root_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				last_q <= last_sample;
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			// drop the block state once the divider holds it
			if (div_start) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end else if (acc_start) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end else if (acc_stat.done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (root_start) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (root_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			res_count_q <= count_q;
			res_ovf_q   <= ovf_q || (in_take && full);
		end
		if (out_load) begin
			rms_q       <= root;
			out_count_q <= res_count_q;
			out_ovf_q   <= res_ovf_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign rms            = rms_q;
	assign sample_count   = out_count_q;
	assign count_overflow = out_ovf_q;

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rlm_pkg::MAX_COUNT)
		else $error("sample count beyond block maximum");

	a_one_unit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({acc_stat.busy, div_stat.busy, root_stat.busy}))
		else $error("more than one arithmetic unit busy");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result word raised outside the output step");

	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_stat.busy || div_stat.busy || root_stat.busy |-> in_stall)
		else $error("sample taken while a unit is working");

endmodule

>>> hw/rtl/rlm_sq_acc.sv
module rlm_sq_acc (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               clear,
	input  logic [rlm_pkg::SAMPLE_W-1:0]       mag,
	output logic [rlm_pkg::SUM_W-1:0]          sum,
	output rlm_pkg::unit_stat_t                stat
);

	logic [rlm_pkg::SAMPLE_W-1:0]   bits_q;
	logic [rlm_pkg::SQ_W-1:0]       addend_q;
	logic [rlm_pkg::SUM_W-1:0]      sum_q;
	logic [rlm_pkg::ACC_STEP_W-1:0] step_q;
	logic                           busy_q;
	logic                           done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			sum_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (clear) begin
				sum_q <= '0;
			end
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				// one multiplier bit per cycle: add the shifted magnitude
				if (bits_q[0]) begin
					sum_q <= sum_q + rlm_pkg::SUM_W'(addend_q);
				end
				step_q <= step_q + 1'b1;
				if (step_q == rlm_pkg::ACC_STEP_W'(rlm_pkg::SAMPLE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bits_q   <= mag;
			addend_q <= rlm_pkg::SQ_W'(mag);
		end else if (busy_q) begin
			bits_q   <= bits_q >> 1;
			addend_q <= addend_q << 1;
		end
	end

	assign sum       = sum_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> hw/rtl/rlm_div.sv
module rlm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rlm_pkg::SUM_W-1:0]    dividend,
	input  logic [rlm_pkg::CNT_W-1:0]    divisor,
	output logic [rlm_pkg::SUM_W-1:0]    quotient,
	output rlm_pkg::unit_stat_t          stat
);

	logic [rlm_pkg::SUM_W-1:0]      dvd_q;
	logic [rlm_pkg::CNT_W-1:0]      dsr_q;
	logic [rlm_pkg::CNT_W-1:0]      rem_q;
	logic [rlm_pkg::DIV_STEP_W-1:0] step_q;
	logic                           busy_q;
	logic                           done_q;
	logic [rlm_pkg::CNT_W:0]        shifted;
	logic                           fits;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, dvd_q[rlm_pkg::SUM_W-1]};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == rlm_pkg::DIV_STEP_W'(rlm_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[rlm_pkg::SUM_W-2:0], fits};
			if (fits) begin
				rem_q <= rlm_pkg::CNT_W'(shifted - {1'b0, dsr_q});
			end else begin
				rem_q <= rlm_pkg::CNT_W'(shifted);
			end
		end
	end

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && dsr_q != '0 |-> rem_q < dsr_q)
		else $error("partial remainder not below divisor");

endmodule

>>> hw/rtl/rlm_sqrt.sv
module rlm_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rlm_pkg::MEAN_W-1:0]    radicand,
	output logic [rlm_pkg::RMS_W-1:0]     root,
	output rlm_pkg::unit_stat_t           stat
);

	localparam int RAD_W = 2 * rlm_pkg::RMS_W;
	localparam int REM_W = rlm_pkg::RMS_W + 2;

	logic [RAD_W-1:0]                rad_q;
	logic [rlm_pkg::RMS_W-1:0]       root_q;
	logic [REM_W-1:0]                rem_q;
	logic [rlm_pkg::ROOT_STEP_W-1:0] step_q;
	logic                            busy_q;
	logic                            done_q;
	logic [REM_W+1:0]                pulled;
	logic [REM_W+1:0]                trial;
	logic                            fits;

	// two radicand bits per cycle, one root bit
	assign pulled = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = pulled >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == rlm_pkg::ROOT_STEP_W'(rlm_pkg::RMS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_W'(radicand);
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			root_q <= {root_q[rlm_pkg::RMS_W-2:0], fits};
			if (fits) begin
				rem_q <= REM_W'(pulled - trial);
			end else begin
				rem_q <= REM_W'(pulled);
			end
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> sim/tb_top.sv
module tb_top;

	localparam int N_WORDS        = 700;
	localparam int HOLD_CYCLES    = 600;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 200;

	typedef struct {
		logic [rlm_pkg::RMS_W-1:0] rms;
		logic [rlm_pkg::CNT_W-1:0] count;
		logic                      ovf;
	} block_level_t;

	class level_tracker;
		block_level_t              pending_levels[$];
		logic [rlm_pkg::SUM_W-1:0] square_sum       = '0;
		logic [rlm_pkg::CNT_W-1:0] samples_in_block = '0;
		logic                      dropped          = 1'b0;
		int                        mismatches       = 0;
		int                        blocks_closed    = 0;
		int                        levels_checked   = 0;

		// Accumulate one accepted word; close the block on the last one.
		function void take_sample(logic signed [rlm_pkg::SAMPLE_W-1:0] s, logic is_last);
			longint          mag;
			longint unsigned mean;
			longint unsigned root;
			longint unsigned trial;
			block_level_t    lvl;
			mag = longint'(s);
			if (mag < 0)
				mag = -mag;
			if (samples_in_block < rlm_pkg::MAX_COUNT) begin
				square_sum += rlm_pkg::SUM_W'(mag * mag);
				samples_in_block++;
			end else begin
				dropped = 1'b1;
			end
			if (!is_last)
				return;
			if (samples_in_block != 0)
				mean = 64'(square_sum / samples_in_block);
			else
				mean = 0;
			// Floor root, one result bit at a time from the top.
			root = 0;
			for (int b = rlm_pkg::RMS_W - 1; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= mean)
					root = trial;
			end
			lvl.rms   = rlm_pkg::RMS_W'(root);
			lvl.count = samples_in_block;
			lvl.ovf   = dropped;
			pending_levels.push_back(lvl);
			blocks_closed++;
			square_sum       = '0;
			samples_in_block = '0;
			dropped          = 1'b0;
		endfunction

		function void check_level(logic [rlm_pkg::RMS_W-1:0] r,
			logic [rlm_pkg::CNT_W-1:0] c, logic o);
			block_level_t want;
			if (pending_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb_top: unexpected level word rms=%0d count=%0d ovf=%0b",
						r, c, o);
				return;
			end
			want = pending_levels.pop_front();
			levels_checked++;
			if (want.rms !== r || want.count !== c || want.ovf !== o) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"tb_top: level %0d mismatch: rms %0d/%0d count %0d/%0d",
						" ovf %0b/%0b (exp/got)"},
						levels_checked, want.rms, r, want.count, c, want.ovf, o);
			end
		endfunction
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	logic signed [rlm_pkg::SAMPLE_W-1:0] sample;
	logic                                last_sample;
	logic                                out_valid;
	logic                                out_stall;
	logic [rlm_pkg::RMS_W-1:0]           rms;
	logic [rlm_pkg::CNT_W-1:0]           sample_count;
	logic                                count_overflow;

	level_tracker tracker;
	int           words_sent    = 0;
	int           longest_block = 0;
	int           idle_cycles   = 0;
	bit           hold_done     = 1'b0;

	rms_level_meter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.last_sample    (last_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.rms            (rms),
		.sample_count   (sample_count),
		.count_overflow (count_overflow)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offer one word and hold it until taken.
	task automatic send_word(input logic signed [rlm_pkg::SAMPLE_W-1:0] s,
		input logic is_last);
		logic taken;
		in_valid    <= 1'b1;
		sample      <= s;
		last_sample <= is_last;
		do begin
			@(negedge clk);
			taken = in_valid && !in_stall;
			@(posedge clk);
		end while (!taken);
		tracker.take_sample(s, is_last);
		words_sent++;
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic send_block(input int len, inout int burst_left);
		logic signed [rlm_pkg::SAMPLE_W-1:0] s;
		for (int i = 0; i < len; i++) begin
			if (burst_left == 0) begin
				pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25));
				burst_left = $urandom_range(1, 60);
			end
			case ($urandom_range(0, 7))
				0: begin
					case ($urandom_range(0, 3))
						0: s = 16'sh8000;
						1: s = 16'sh7fff;
						2: s = '0;
						default: s = -16'sd1;
					endcase
				end
				1: s = $signed(16'($urandom_range(0, 30))) - 16'sd15;
				default: s = 16'($urandom_range(0, 65535));
			endcase
			send_word(s, i == len - 1);
			burst_left--;
		end
		if (len > longest_block)
			longest_block = len;
	endtask

	initial begin
		int burst_left;
		int len;
		tracker     = new;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		sample      = '0;
		last_sample = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// single-word blocks at the extremes, then short mixed blocks
		send_word(16'sh8000, 1'b1);
		send_word(16'sh7fff, 1'b1);
		send_word(16'sd0, 1'b1);
		send_word(-16'sd1, 1'b1);
		send_word(16'sh7fff, 1'b0); send_word(16'sh8000, 1'b1);
		send_word(16'sd1, 1'b0); send_word(16'sd0, 1'b0); send_word(16'sd0, 1'b1);
		send_word(16'sd100, 1'b0); send_word(-16'sd100, 1'b0);
		send_word(16'sd100, 1'b0); send_word(-16'sd100, 1'b1);
		repeat (7) send_word(16'sh8000, 1'b0);
		send_word(16'sh8000, 1'b1);
		send_word(16'sd3, 1'b0); send_word(16'sd4, 1'b1);
		longest_block = 8;

		burst_left = 0;
		while (words_sent < N_WORDS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: len = $urandom_range(1, 6);
				6, 7, 8: len = $urandom_range(7, 20);
				default: len = $urandom_range(21, 80);
			endcase
			send_block(len, burst_left);
		end
		in_valid <= 1'b0;

		while (tracker.pending_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb_top: %0d samples in %0d blocks (longest %0d), %0d levels compared",
			words_sent, tracker.blocks_closed, longest_block, tracker.levels_checked);
		$display("tb_top: output hold-off of %0d cycles %s; full-count path not reached",
			HOLD_CYCLES, hold_done ? "applied" : "missed");
		if (tracker.mismatches == 0 && tracker.pending_levels.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// Output stall pattern, with one long hold-off once levels are flowing.
	initial begin
		int mode;
		int len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			len  = $urandom_range(20, 200);
			repeat (len) begin
				@(posedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= 1'($urandom_range(0, 1));
				endcase
			end
			if (!hold_done && tracker.levels_checked >= 10) begin
				hold_done = 1'b1;
				@(posedge clk);
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	// Sample both handshakes mid-cycle, where everything driven at the edge is settled.
	initial begin
		logic took_in;
		logic took_out;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if (arst_n) begin
				took_in  = in_valid && !in_stall;
				took_out = out_valid && !out_stall;
				if (took_out)
					tracker.check_level(rms, sample_count, count_overflow);
				if (took_in || took_out)
					idle_cycles = 0;
				else
					idle_cycles++;
			end
		end
		$display("tb_top: no handshake for %0d cycles, %0d levels outstanding",
			WATCHDOG_LIMIT, tracker.pending_levels.size());
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

>>> rms_level_meter.f
hw/rtl/rlm_pkg.sv
hw/rtl/rlm_sq_acc.sv
hw/rtl/rlm_div.sv
hw/rtl/rlm_sqrt.sv
hw/rtl/rms_level_meter.sv
sim/tb_top.sv
